// ===== design/pfdm_pkg.sv =====
// Package: shared types and constants of the pulse frequency and duty meter.
package pfdm_pkg;

  localparam int unsigned SampleBits  = 16;
  localparam int unsigned IndexBits   = 24;
  localparam int unsigned QueueDepth  = 4;
  localparam int unsigned QueuePtrW   = $clog2(QueueDepth);
  localparam int unsigned DivSteps    = 32;
  localparam int unsigned DutySteps   = 16;
  localparam int unsigned StepCntW    = $clog2(DivSteps);

  // Register indexes
  localparam logic [2:0] REG_LOW_THR   = 3'd0;
  localparam logic [2:0] REG_HIGH_THR  = 3'd1;
  localparam logic [2:0] REG_RATE      = 3'd2;
  localparam logic [2:0] REG_MIN_FREQ  = 3'd3;
  localparam logic [2:0] REG_MAX_FREQ  = 3'd4;
  localparam logic [2:0] REG_MIN_DUTY  = 3'd5;
  localparam logic [2:0] REG_MAX_DUTY  = 3'd6;
  localparam logic [2:0] REG_ALLOWED   = 3'd7;

  // Result kinds and record status codes
  localparam logic       KIND_PERIOD   = 1'b0;
  localparam logic       KIND_VERDICT  = 1'b1;
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_FEW      = 2'd1;
  localparam logic [1:0] STATUS_INVERTED = 2'd2;

  typedef enum logic [2:0] {
    LVL_LOW  = 3'b001,
    LVL_MID  = 3'b010,
    LVL_HIGH = 3'b100
  } level_e;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_PER  = 4'b0100,
    ST_VER  = 4'b1000
  } back_state_e;

  typedef struct packed {
    logic signed [SampleBits-1:0] sample;
    logic                         end_of_record;
  } in_t;

  typedef struct packed {
    logic        result_kind;
    logic [23:0] period_samples;
    logic [23:0] high_samples;
    logic [31:0] frequency;
    logic [15:0] duty;
    logic        frequency_in_range;
    logic        duty_in_range;
    logic        frequency_pass;
    logic        duty_pass;
    logic [1:0]  record_status;
    logic        last_result;
  } out_t;

  typedef struct packed {
    logic signed [15:0] low_threshold;
    logic signed [15:0] high_threshold;
    logic [23:0]        sample_rate;
    logic [31:0]        min_frequency;
    logic [31:0]        max_frequency;
    logic [16:0]        min_duty;
    logic [16:0]        max_duty;
    logic [23:0]        allowed_misses;
  } cfg_t;

  // One queued job: an optional period measurement and an optional verdict
  typedef struct packed {
    logic                 has_period;
    logic [IndexBits-1:0] period;
    logic [IndexBits-1:0] high;
    logic                 has_verdict;
    logic [1:0]           status;
  } job_t;

endpackage

// ===== design/pfdm_front.sv =====
// Front end: hysteresis edge detector and record bookkeeping, emits jobs.
module pfdm_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  pfdm_pkg::cfg_t cfg_i,
  input  logic          accept_i,
  input  pfdm_pkg::in_t in_data_i,
  output logic          push_o,
  output pfdm_pkg::job_t job_o
);

  localparam logic [pfdm_pkg::IndexBits-1:0] IdxMax = '1;

  pfdm_pkg::level_e level_q, level_d;
  logic started_q, started_d;
  logic rseen_q, rseen_d;
  logic [1:0] ecnt_q, ecnt_d;
  logic [pfdm_pkg::IndexBits-1:0] sidx_q, sidx_d, ridx_q, ridx_d, fidx_q, fidx_d;

  logic signed [pfdm_pkg::SampleBits-1:0] smp;
  logic is_hi, is_lo, inv;

  assign smp   = in_data_i.sample;
  assign inv   = cfg_i.high_threshold < cfg_i.low_threshold;
  assign is_hi = smp >= cfg_i.high_threshold;
  assign is_lo = smp <= cfg_i.low_threshold;

  // Next record state and job for one sample
  always_comb begin
    level_d   = level_q;
    started_d = started_q;
    rseen_d   = rseen_q;
    ecnt_d    = ecnt_q;
    sidx_d    = sidx_q;
    ridx_d    = ridx_q;
    fidx_d    = fidx_q;
    job_o     = '0;
    if (!started_q) begin
      started_d = 1'b1;
      if (!inv) begin
        if (is_hi) level_d = pfdm_pkg::LVL_HIGH;
        else if (is_lo) level_d = pfdm_pkg::LVL_LOW;
        else level_d = pfdm_pkg::LVL_MID;
      end
    end else if (!inv) begin
      unique case (level_q)
        pfdm_pkg::LVL_HIGH: begin
          if (is_lo) begin
            if (ecnt_q != 2'd3) ecnt_d = ecnt_q + 2'd1;
            fidx_d  = sidx_q;
            level_d = pfdm_pkg::LVL_LOW;
          end
        end
        pfdm_pkg::LVL_LOW: begin
          if (is_hi) begin
            if (ecnt_q != 2'd3) ecnt_d = ecnt_q + 2'd1;
            if (rseen_q) begin
              job_o.has_period = 1'b1;
              job_o.period     = sidx_q - ridx_q;
              job_o.high       = fidx_q - ridx_q;
            end
            ridx_d  = sidx_q;
            rseen_d = 1'b1;
            level_d = pfdm_pkg::LVL_HIGH;
          end
        end
        default: begin
          if (is_hi) level_d = pfdm_pkg::LVL_HIGH;
          else if (is_lo) level_d = pfdm_pkg::LVL_LOW;
        end
      endcase
    end
    if (sidx_q != IdxMax) sidx_d = sidx_q + 1'b1;
    // Close the record: verdict job, then back to reset state
    if (in_data_i.end_of_record) begin
      job_o.has_verdict = 1'b1;
      if (inv) job_o.status = pfdm_pkg::STATUS_INVERTED;
      else if (ecnt_d != 2'd3) job_o.status = pfdm_pkg::STATUS_FEW;
      else job_o.status = pfdm_pkg::STATUS_OK;
      level_d   = pfdm_pkg::LVL_MID;
      started_d = 1'b0;
      rseen_d   = 1'b0;
      ecnt_d    = '0;
      sidx_d    = '0;
      ridx_d    = '0;
      fidx_d    = '0;
    end
  end

  assign push_o = accept_i & (job_o.has_period | job_o.has_verdict);

  // Advance record state on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q   <= pfdm_pkg::LVL_MID;
      started_q <= 1'b0;
      rseen_q   <= 1'b0;
      ecnt_q    <= '0;
      sidx_q    <= '0;
      ridx_q    <= '0;
      fidx_q    <= '0;
    end else if (accept_i) begin
      level_q   <= level_d;
      started_q <= started_d;
      rseen_q   <= rseen_d;
      ecnt_q    <= ecnt_d;
      sidx_q    <= sidx_d;
      ridx_q    <= ridx_d;
      fidx_q    <= fidx_d;
    end
  end

endmodule

// ===== design/pfdm_queue.sv =====
// Job queue between the front end and the back end.
module pfdm_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pfdm_pkg::job_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output pfdm_pkg::job_t pop_data_o
);

  pfdm_pkg::job_t mem_q [pfdm_pkg::QueueDepth];
  logic [pfdm_pkg::QueuePtrW:0] wptr_q, rptr_q;

  assign empty_o = wptr_q == rptr_q;
  assign full_o  = (wptr_q[pfdm_pkg::QueuePtrW] != rptr_q[pfdm_pkg::QueuePtrW]) &&
                   (wptr_q[pfdm_pkg::QueuePtrW-1:0] == rptr_q[pfdm_pkg::QueuePtrW-1:0]);
  assign pop_data_o = mem_q[rptr_q[pfdm_pkg::QueuePtrW-1:0]];

  // Store pushed jobs
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q[pfdm_pkg::QueuePtrW-1:0]] <= push_data_i;
  end

  // Advance pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + 1'b1;
      if (pop_i)  rptr_q <= rptr_q + 1'b1;
    end
  end

endmodule

// ===== design/pfdm_back.sv =====
// Back end: bit-serial dividers, range checks, miss counters, result register.
module pfdm_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  pfdm_pkg::cfg_t  cfg_i,
  input  logic            empty_i,
  input  pfdm_pkg::job_t  job_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output pfdm_pkg::out_t  out_data_o
);

  localparam logic [23:0] MissMax = '1;
  localparam logic [pfdm_pkg::StepCntW-1:0] LastStep = pfdm_pkg::StepCntW'(pfdm_pkg::DivSteps - 1);

  pfdm_pkg::back_state_e state_q, state_d;
  pfdm_pkg::job_t job_q;
  pfdm_pkg::out_t out_q;
  logic out_valid_q;
  logic [31:0] fnum_q, fquo_q;
  logic [23:0] frem_q, drem_q;
  logic [15:0] dquo_q;
  logic dsat_q, pzero_q;
  logic [pfdm_pkg::StepCntW-1:0] cnt_q;
  logic [23:0] fmiss_q, dmiss_q;

  logic [24:0] fr, dr;
  logic fge, dge, out_free, load_per, load_ver;
  logic [31:0] freq;
  logic [15:0] duty;
  logic fin, din;

  // One restoring step for each divider
  assign fr  = {frem_q, fnum_q[31]};
  assign fge = fr >= {1'b0, job_q.period};
  assign dr  = {drem_q, 1'b0};
  assign dge = dr >= {1'b0, job_q.period};

  assign freq = pzero_q ? '1 : fquo_q;
  assign duty = pzero_q ? '0 : (dsat_q ? '1 : dquo_q);
  assign fin  = (freq >= cfg_i.min_frequency) && (freq <= cfg_i.max_frequency);
  assign din  = ({1'b0, duty} >= cfg_i.min_duty) && ({1'b0, duty} <= cfg_i.max_duty);

  assign out_free = !out_valid_q || out_ready_i;
  assign pop_o    = (state_q == pfdm_pkg::ST_IDLE) && !empty_i;
  assign load_per = (state_q == pfdm_pkg::ST_PER) && out_free;
  assign load_ver = (state_q == pfdm_pkg::ST_VER) && out_free;

  // Sequence one job
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pfdm_pkg::ST_IDLE: begin
        if (!empty_i) state_d = job_i.has_period ? pfdm_pkg::ST_DIV : pfdm_pkg::ST_VER;
      end
      pfdm_pkg::ST_DIV: if (cnt_q == LastStep) state_d = pfdm_pkg::ST_PER;
      pfdm_pkg::ST_PER: begin
        if (out_free) state_d = job_q.has_verdict ? pfdm_pkg::ST_VER : pfdm_pkg::ST_IDLE;
      end
      pfdm_pkg::ST_VER: if (out_free) state_d = pfdm_pkg::ST_IDLE;
      default: state_d = pfdm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pfdm_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      fmiss_q     <= '0;
      dmiss_q     <= '0;
    end else begin
      state_q <= state_d;
      if (load_per || load_ver) out_valid_q <= 1'b1;
      else if (out_ready_i)     out_valid_q <= 1'b0;
      // Count misses per period, clear them with the verdict
      if (load_per) begin
        if (!fin && fmiss_q != MissMax) fmiss_q <= fmiss_q + 24'd1;
        if (!din && dmiss_q != MissMax) dmiss_q <= dmiss_q + 24'd1;
      end else if (load_ver) begin
        fmiss_q <= '0;
        dmiss_q <= '0;
      end
    end
  end

  // Datapath: job latch, divider iterations, result register
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q   <= job_i;
      fnum_q  <= {cfg_i.sample_rate, 8'd0};
      frem_q  <= '0;
      fquo_q  <= '0;
      dsat_q  <= job_i.high >= job_i.period;
      drem_q  <= (job_i.high >= job_i.period) ? '0 : job_i.high;
      dquo_q  <= '0;
      pzero_q <= job_i.period == '0;
      cnt_q   <= '0;
    end else if (state_q == pfdm_pkg::ST_DIV) begin
      fnum_q <= {fnum_q[30:0], 1'b0};
      frem_q <= fge ? 24'(fr - {1'b0, job_q.period}) : fr[23:0];
      fquo_q <= {fquo_q[30:0], fge};
      if (cnt_q < pfdm_pkg::StepCntW'(pfdm_pkg::DutySteps)) begin
        drem_q <= dge ? 24'(dr - {1'b0, job_q.period}) : dr[23:0];
        dquo_q <= {dquo_q[14:0], dge};
      end
      cnt_q <= cnt_q + 1'b1;
    end
    if (load_per) begin
      out_q                    <= '0;
      out_q.result_kind        <= pfdm_pkg::KIND_PERIOD;
      out_q.period_samples     <= job_q.period;
      out_q.high_samples       <= job_q.high;
      out_q.frequency          <= freq;
      out_q.duty               <= duty;
      out_q.frequency_in_range <= fin;
      out_q.duty_in_range      <= din;
      out_q.record_status      <= pfdm_pkg::STATUS_OK;
      out_q.last_result        <= !job_q.has_verdict;
    end else if (load_ver) begin
      out_q                <= '0;
      out_q.result_kind    <= pfdm_pkg::KIND_VERDICT;
      out_q.record_status  <= job_q.status;
      out_q.frequency_pass <= (job_q.status == pfdm_pkg::STATUS_OK) &&
                              (fmiss_q <= cfg_i.allowed_misses);
      out_q.duty_pass      <= (job_q.status == pfdm_pkg::STATUS_OK) &&
                              (dmiss_q <= cfg_i.allowed_misses);
      out_q.last_result    <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== design/pulse_frequency_duty_meter.sv =====
// Top level: register port, front end, job queue and back end of the meter.
// Samples are taken one per cycle while the four-entry job queue has room. For each period
// the back end runs a 32-step bit-serial pass of the frequency divider, during which the duty
// divider also works, then loads the period result; a verdict is loaded after it or alone.
// Each load waits until the result register is free.
// Reset (rst_ni, asynchronous, active low) restores registers to defaults and clears
// record state, the queue and the output valid flag.
module pulse_frequency_duty_meter (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  pfdm_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output pfdm_pkg::out_t out_data_o,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [4:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  pfdm_pkg::cfg_t cfg_q;
  pfdm_pkg::job_t push_job, pop_job;
  logic push, pop, full, empty, accept, wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_threshold  <= -16'sd1000;
      cfg_q.high_threshold <= 16'sd1000;
      cfg_q.sample_rate    <= 24'd1000000;
      cfg_q.min_frequency  <= '0;
      cfg_q.max_frequency  <= '1;
      cfg_q.min_duty       <= '0;
      cfg_q.max_duty       <= 17'd65536;
      cfg_q.allowed_misses <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        pfdm_pkg::REG_LOW_THR:  cfg_q.low_threshold  <= pwdata[15:0];
        pfdm_pkg::REG_HIGH_THR: cfg_q.high_threshold <= pwdata[15:0];
        pfdm_pkg::REG_RATE:     cfg_q.sample_rate    <= pwdata[23:0];
        pfdm_pkg::REG_MIN_FREQ: cfg_q.min_frequency  <= pwdata;
        pfdm_pkg::REG_MAX_FREQ: cfg_q.max_frequency  <= pwdata;
        pfdm_pkg::REG_MIN_DUTY: cfg_q.min_duty       <= pwdata[16:0];
        pfdm_pkg::REG_MAX_DUTY: cfg_q.max_duty       <= pwdata[16:0];
        pfdm_pkg::REG_ALLOWED:  cfg_q.allowed_misses <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  // Read back registers
  always_comb begin
    unique case (reg_idx)
      pfdm_pkg::REG_LOW_THR:  prdata = {16'd0, cfg_q.low_threshold};
      pfdm_pkg::REG_HIGH_THR: prdata = {16'd0, cfg_q.high_threshold};
      pfdm_pkg::REG_RATE:     prdata = {8'd0, cfg_q.sample_rate};
      pfdm_pkg::REG_MIN_FREQ: prdata = cfg_q.min_frequency;
      pfdm_pkg::REG_MAX_FREQ: prdata = cfg_q.max_frequency;
      pfdm_pkg::REG_MIN_DUTY: prdata = {15'd0, cfg_q.min_duty};
      pfdm_pkg::REG_MAX_DUTY: prdata = {15'd0, cfg_q.max_duty};
      pfdm_pkg::REG_ALLOWED:  prdata = {8'd0, cfg_q.allowed_misses};
      default:                prdata = '0;
    endcase
  end

  assign in_ready_o = !full;
  assign accept     = in_valid_i && !full;

  pfdm_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .accept_i  (accept),
    .in_data_i (in_data_i),
    .push_o    (push),
    .job_o     (push_job)
  );

  pfdm_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .pop_data_o  (pop_job)
  );

  pfdm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .empty_i     (empty),
    .job_i       (pop_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

`ifndef ASSERT_OFF
  a_verdict_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.result_kind |-> out_data_o.last_result)
    else $error("verdict beat not marked last");
  a_period_no_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.result_kind |->
      out_data_o.record_status == pfdm_pkg::STATUS_OK &&
      !out_data_o.frequency_pass && !out_data_o.duty_pass)
    else $error("period beat carries verdict fields");
  a_verdict_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.result_kind |->
      out_data_o.period_samples == '0 && out_data_o.frequency == '0)
    else $error("verdict beat carries period fields");
  a_failed_no_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.record_status != pfdm_pkg::STATUS_OK |->
      !out_data_o.frequency_pass && !out_data_o.duty_pass)
    else $error("failed record reports a pass");
`endif

endmodule
